// ===== src/pfps_pkg.sv =====
// Shared types and codes for the page frame buffer with pixel scroll.
// Used by page_framebuffer_pixel_scroll; no dependencies.
`default_nettype none

package pfps_pkg;

    // bits in one frame store byte (one column of one page)
    localparam int unsigned PIX_PER_BYTE = 8;

    // command codes
    typedef enum logic [1:0] {
        MODE_DRAW   = 2'd0,
        MODE_CLEAR  = 2'd1,
        MODE_SCROLL = 2'd2,
        MODE_READ   = 2'd3
    } t_mode;

    // sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CLR    = 7'b0000010,
        S_PIX    = 7'b0000100,
        S_READ   = 7'b0001000,
        S_SCRL_A = 7'b0010000,
        S_SCRL_B = 7'b0100000,
        S_SCRL_C = 7'b1000000
    } t_state;

endpackage

`default_nettype wire

// ===== src/page_framebuffer_pixel_scroll.sv =====
// Page organized monochrome frame buffer: pixel draw, clear, scroll up, byte read.
// Depends on pfps_pkg (codes, state type) and pfps_ram (frame store).
//
//  channel   signals                                         direction  handshake
//  command   start, busy, i_mode, i_pixel_x, i_pixel_y,      in         start && !busy
//            i_pixel_on, i_scroll_amount, i_read_address
//  result    o_done, o_read_data                             out        o_done, one cycle
//
// Draw and read issue the frame store read on accept, then write back or capture
// in S_PIX or S_READ; the result strobe follows in the next cycle, busy already low.
// Clear writes the whole store, one zero byte per cycle.
// Scroll makes two reads of the single read port and one write per destination
// byte (S_SCRL_A, S_SCRL_B, S_SCRL_C). Zero scroll answers in the next cycle.
// After reset the store is swept to zero (1024 bytes at default size) with busy
// high. Results cannot be stalled.
`default_nettype none

module page_framebuffer_pixel_scroll #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] i_mode,
    input  wire logic [7:0] i_pixel_x,
    input  wire logic [7:0] i_pixel_y,
    input  wire logic       i_pixel_on,
    input  wire logic [7:0] i_scroll_amount,
    input  wire logic [9:0] i_read_address,
    output logic            o_done,
    output logic [7:0]      o_read_data
);

    localparam int PAGE_COUNT = SCREEN_HEIGHT / 8;
    localparam int ROW_COUNT  = PAGE_COUNT * 8;
    localparam int STORE_SIZE = SCREEN_WIDTH * PAGE_COUNT;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int PAGE_W     = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int COL_W      = $clog2(SCREEN_WIDTH);
    localparam int BYTE_W     = pfps_pkg::PIX_PER_BYTE;

    pfps_pkg::t_state r_state, n_state;
    logic [ADDR_W-1:0] r_dst, n_dst;
    logic [PAGE_W-1:0] r_page, n_page;
    logic [COL_W-1:0]  r_col, n_col;
    logic [PAGE_W-1:0] r_pshift, n_pshift;
    logic [2:0]        r_bshift, n_bshift;
    logic [ADDR_W-1:0] r_qoff, n_qoff;
    logic              r_ok, n_ok;
    logic              r_on, n_on;
    logic              r_reply, n_reply;
    logic [BYTE_W-1:0] r_lo, n_lo;
    logic              r_done, n_done;
    logic [BYTE_W-1:0] r_read_data, n_read_data;

    logic              w_accept;
    pfps_pkg::t_mode   w_mode;
    logic              w_pix_ok;
    logic              w_rd_ok;
    logic [ADDR_W-1:0] w_pix_addr;
    logic [ADDR_W:0]   w_src_lo;
    logic [ADDR_W:0]   w_src_hi;
    logic [PAGE_W:0]   w_pg_lo;
    logic              w_lo_zero;
    logic              w_hi_zero;
    logic              w_last;
    logic              w_col_last;
    logic [BYTE_W-1:0] w_hi;
    logic [2*BYTE_W-1:0] w_pair;
    logic [BYTE_W-1:0] w_mask;

    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [BYTE_W-1:0] w_wdata;
    logic [ADDR_W-1:0] w_raddr;
    logic [BYTE_W-1:0] w_rdata;

    // frame store
    pfps_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_SIZE)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // command decode
    assign busy       = (r_state != pfps_pkg::S_IDLE);
    assign w_accept   = start && !busy;
    assign w_mode     = pfps_pkg::t_mode'(i_mode);
    assign w_pix_ok   = (32'(i_pixel_x) < SCREEN_WIDTH) && (32'(i_pixel_y) < ROW_COUNT);
    assign w_rd_ok    = (32'(i_read_address) < STORE_SIZE);
    assign w_pix_addr = ADDR_W'((32'(i_pixel_y) >> 3) * 32'(SCREEN_WIDTH)
                                + 32'(i_pixel_x));

    // scroll source addressing and below-screen detection
    assign w_src_lo   = {1'b0, r_dst} + {1'b0, r_qoff};
    assign w_src_hi   = w_src_lo + (ADDR_W+1)'(SCREEN_WIDTH);
    assign w_pg_lo    = {1'b0, r_page} + {1'b0, r_pshift};
    assign w_lo_zero  = (32'(w_pg_lo) >= PAGE_COUNT);
    assign w_hi_zero  = (32'(w_pg_lo) + 32'd1 >= PAGE_COUNT);
    assign w_last     = (r_dst == ADDR_W'(STORE_SIZE - 1));
    assign w_col_last = (r_col == COL_W'(SCREEN_WIDTH - 1));

    // byte assembly for scroll and pixel update
    assign w_hi   = w_hi_zero ? '0 : w_rdata;
    assign w_pair = {w_hi, r_lo} >> r_bshift;
    assign w_mask = BYTE_W'(1) << r_bshift;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_dst       = r_dst;
        n_page      = r_page;
        n_col       = r_col;
        n_pshift    = r_pshift;
        n_bshift    = r_bshift;
        n_qoff      = r_qoff;
        n_ok        = r_ok;
        n_on        = r_on;
        n_reply     = r_reply;
        n_lo        = r_lo;
        n_done      = 1'b0;
        n_read_data = '0;
        w_we        = 1'b0;
        w_waddr     = r_dst;
        w_wdata     = '0;
        w_raddr     = r_dst;

        unique case (r_state)
            pfps_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (w_mode)
                        pfps_pkg::MODE_DRAW: begin
                            n_ok     = w_pix_ok;
                            n_on     = i_pixel_on;
                            n_bshift = i_pixel_y[2:0];
                            n_dst    = w_pix_ok ? w_pix_addr : '0;
                            w_raddr  = w_pix_ok ? w_pix_addr : '0;
                            n_state  = pfps_pkg::S_PIX;
                        end
                        pfps_pkg::MODE_CLEAR: begin
                            n_dst   = '0;
                            n_reply = 1'b1;
                            n_state = pfps_pkg::S_CLR;
                        end
                        pfps_pkg::MODE_SCROLL: begin
                            if (i_scroll_amount == 8'd0) begin
                                n_done = 1'b1;
                            end else if (32'(i_scroll_amount) >= ROW_COUNT) begin
                                n_dst   = '0;
                                n_reply = 1'b1;
                                n_state = pfps_pkg::S_CLR;
                            end else begin
                                n_dst    = '0;
                                n_page   = '0;
                                n_col    = '0;
                                n_pshift = PAGE_W'(i_scroll_amount >> 3);
                                n_bshift = i_scroll_amount[2:0];
                                n_qoff   = ADDR_W'(32'(i_scroll_amount >> 3)
                                                   * 32'(SCREEN_WIDTH));
                                n_state  = pfps_pkg::S_SCRL_A;
                            end
                        end
                        pfps_pkg::MODE_READ: begin
                            n_ok    = w_rd_ok;
                            w_raddr = w_rd_ok ? ADDR_W'(i_read_address) : '0;
                            n_state = pfps_pkg::S_READ;
                        end
                        default: begin
                            n_state = pfps_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            pfps_pkg::S_CLR: begin
                // sweep one zero byte per cycle
                w_we    = 1'b1;
                w_wdata = '0;
                n_dst   = r_dst + ADDR_W'(1);
                if (w_last) begin
                    n_done  = r_reply;
                    n_state = pfps_pkg::S_IDLE;
                end
            end
            pfps_pkg::S_PIX: begin
                // read-modify-write of the addressed byte
                w_we    = r_ok;
                w_wdata = r_on ? (w_rdata | w_mask) : (w_rdata & ~w_mask);
                n_done  = 1'b1;
                n_state = pfps_pkg::S_IDLE;
            end
            pfps_pkg::S_READ: begin
                n_read_data = r_ok ? w_rdata : '0;
                n_done      = 1'b1;
                n_state     = pfps_pkg::S_IDLE;
            end
            pfps_pkg::S_SCRL_A: begin
                // fetch the upper source page
                w_raddr = w_lo_zero ? r_dst : w_src_lo[ADDR_W-1:0];
                n_state = pfps_pkg::S_SCRL_B;
            end
            pfps_pkg::S_SCRL_B: begin
                // fetch the lower source page, keep the upper one
                w_raddr = w_hi_zero ? r_dst : w_src_hi[ADDR_W-1:0];
                n_lo    = w_lo_zero ? '0 : w_rdata;
                n_state = pfps_pkg::S_SCRL_C;
            end
            pfps_pkg::S_SCRL_C: begin
                // merge the two bytes and write the destination
                w_we    = 1'b1;
                w_wdata = w_pair[BYTE_W-1:0];
                n_dst   = r_dst + ADDR_W'(1);
                if (w_col_last) begin
                    n_col  = '0;
                    n_page = r_page + PAGE_W'(1);
                end else begin
                    n_col  = r_col + COL_W'(1);
                end
                if (w_last) begin
                    n_done  = 1'b1;
                    n_state = pfps_pkg::S_IDLE;
                end else begin
                    n_state = pfps_pkg::S_SCRL_A;
                end
            end
            default: begin
                n_state = pfps_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfps_pkg::S_CLR;
            r_dst   <= '0;
            r_reply <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dst   <= n_dst;
            r_reply <= n_reply;
            r_done  <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_page      <= n_page;
        r_col       <= n_col;
        r_pshift    <= n_pshift;
        r_bshift    <= n_bshift;
        r_qoff      <= n_qoff;
        r_ok        <= n_ok;
        r_on        <= n_on;
        r_lo        <= n_lo;
        r_read_data <= n_read_data;
    end

    assign o_done      = r_done;
    assign o_read_data = r_read_data;

    // checks
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_mode == pfps_pkg::MODE_READ) |=> ##1 o_done)
        else $error("read result not delivered two cycles after accept");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while sequencer still busy");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !w_we)
        else $error("frame store written while idle");

    a_scroll_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pfps_pkg::S_SCRL_A) |=> (r_state == pfps_pkg::S_SCRL_B))
        else $error("scroll fetch phases out of order");

endmodule

`default_nettype wire

// ===== src/pfps_ram.sv =====
// Generic simple dual port RAM, one write port and one registered read port.
// Standalone; no package dependencies.
`default_nettype none

module pfps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== tb/tb_page_framebuffer_pixel_scroll.sv =====
// Testbench for page_framebuffer_pixel_scroll: directed and random commands checked
// against a bit-level frame store predictor. Depends on pfps_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_page_framebuffer_pixel_scroll;

    localparam int FB_W       = 128;
    localparam int FB_H       = 64;
    localparam int FB_PAGES   = FB_H / pfps_pkg::PIX_PER_BYTE;
    localparam int FB_BYTES   = FB_W * FB_PAGES;
    localparam int RAND_CMDS  = 400;
    // longest quiet gap: reset sweep or a full scroll, plus sender gaps, with margin
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        pfps_pkg::t_mode mode;
        logic [7:0]      px;
        logic [7:0]      py;
        logic            on;
        logic [7:0]      amount;
        logic [9:0]      addr;
    } t_fb_cmd;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       start           = 1'b0;
    logic [1:0] i_mode          = '0;
    logic [7:0] i_pixel_x       = '0;
    logic [7:0] i_pixel_y       = '0;
    logic       i_pixel_on      = 1'b0;
    logic [7:0] i_scroll_amount = '0;
    logic [9:0] i_read_address  = '0;
    logic       busy;
    logic       o_done;
    logic [7:0] o_read_data;

    page_framebuffer_pixel_scroll dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_pixel_x       (i_pixel_x),
        .i_pixel_y       (i_pixel_y),
        .i_pixel_on      (i_pixel_on),
        .i_scroll_amount (i_scroll_amount),
        .i_read_address  (i_read_address),
        .o_done          (o_done),
        .o_read_data     (o_read_data)
    );

    t_fb_cmd    pending_cmds[$];
    logic [7:0] due_bytes[$];
    logic [7:0] frame_image[FB_BYTES];
    t_fb_cmd    drv_cmd;
    int         beats_sent  = 0;
    int         err_count   = 0;
    int         stall_count = 0;
    bit         idle_now;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // predictor: applies one command to the frame image, returns the expected byte
    function automatic logic [7:0] frame_apply(t_fb_cmd c);
        logic [7:0] snap[FB_BYTES];
        logic [7:0] nb;
        int         src;
        logic [7:0] res;
        res = 8'h00;
        case (c.mode)
            pfps_pkg::MODE_DRAW: begin
                if (c.px < FB_W && c.py < FB_H)
                    frame_image[(c.py >> 3) * FB_W + c.px][c.py[2:0]] = c.on;
            end
            pfps_pkg::MODE_CLEAR: begin
                foreach (frame_image[i]) frame_image[i] = 8'h00;
            end
            pfps_pkg::MODE_SCROLL: begin
                if (c.amount >= FB_H) begin
                    foreach (frame_image[i]) frame_image[i] = 8'h00;
                end else if (c.amount != 0) begin
                    snap = frame_image;
                    for (int p = 0; p < FB_PAGES; p++) begin
                        for (int col = 0; col < FB_W; col++) begin
                            nb = 8'h00;
                            for (int b = 0; b < pfps_pkg::PIX_PER_BYTE; b++) begin
                                // rows pulled from below the screen read as zero
                                src = p * pfps_pkg::PIX_PER_BYTE + b + c.amount;
                                if (src < FB_H)
                                    nb[b] = snap[(src >> 3) * FB_W + col]
                                                [src % pfps_pkg::PIX_PER_BYTE];
                            end
                            frame_image[p * FB_W + col] = nb;
                        end
                    end
                end
            end
            pfps_pkg::MODE_READ: begin
                if (c.addr < FB_BYTES)
                    res = frame_image[c.addr];
            end
            default: ;
        endcase
        return res;
    endfunction

    // fields a mode does not use carry random bits
    task automatic add_cmd(pfps_pkg::t_mode m, int a, int b, bit on);
        t_fb_cmd c;
        c.px     = 8'($urandom);
        c.py     = 8'($urandom);
        c.on     = 1'($urandom);
        c.amount = 8'($urandom);
        c.addr   = 10'($urandom);
        c.mode   = m;
        case (m)
            pfps_pkg::MODE_DRAW: begin
                c.px = 8'(a);
                c.py = 8'(b);
                c.on = on;
            end
            pfps_pkg::MODE_SCROLL: c.amount = 8'(a);
            pfps_pkg::MODE_READ:   c.addr = 10'(a);
            default: ;
        endcase
        pending_cmds.push_back(c);
    endtask

    // command driver: a beat moves on start && !busy
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                due_bytes.push_back(frame_apply(drv_cmd));
                beats_sent++;
            end
            if (!start || !busy) begin
                // no idling in a long stretch in the middle of the run
                idle_now = (beats_sent >= 150 && beats_sent < 260) ? 1'b0
                         : ($urandom_range(99) < 12);
                if (pending_cmds.size() > 0 && !idle_now) begin
                    drv_cmd = pending_cmds.pop_front();
                    start           <= 1'b1;
                    i_mode          <= drv_cmd.mode;
                    i_pixel_x       <= drv_cmd.px;
                    i_pixel_y       <= drv_cmd.py;
                    i_pixel_on      <= drv_cmd.on;
                    i_scroll_amount <= drv_cmd.amount;
                    i_read_address  <= drv_cmd.addr;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // result monitor: compare each strobed byte with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (due_bytes.size() == 0) begin
                $display("%0t: result beat with nothing outstanding, got %02h",
                         $time, o_read_data);
                err_count++;
            end else begin
                logic [7:0] want;
                want = due_bytes.pop_front();
                if (o_read_data !== want) begin
                    $display("%0t: read_data mismatch, expected %02h, got %02h",
                             $time, want, o_read_data);
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles with no beat in either direction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int r;
        int x;
        int y;

        foreach (frame_image[i]) frame_image[i] = 8'h00;

        // corners, center, off-screen pixels
        add_cmd(pfps_pkg::MODE_DRAW, 0, 0, 1'b1);
        add_cmd(pfps_pkg::MODE_DRAW, 127, 63, 1'b1);
        add_cmd(pfps_pkg::MODE_DRAW, 127, 0, 1'b1);
        add_cmd(pfps_pkg::MODE_DRAW, 0, 63, 1'b1);
        add_cmd(pfps_pkg::MODE_DRAW, 64, 31, 1'b1);
        add_cmd(pfps_pkg::MODE_DRAW, 128, 10, 1'b1);
        add_cmd(pfps_pkg::MODE_DRAW, 255, 255, 1'b1);
        add_cmd(pfps_pkg::MODE_DRAW, 5, 64, 1'b1);
        add_cmd(pfps_pkg::MODE_READ, 0, 0, 1'b0);
        add_cmd(pfps_pkg::MODE_READ, 1023, 0, 1'b0);
        add_cmd(pfps_pkg::MODE_READ, 896, 0, 1'b0);
        add_cmd(pfps_pkg::MODE_READ, 3 * FB_W + 64, 0, 1'b0);
        // erase a pixel
        add_cmd(pfps_pkg::MODE_DRAW, 127, 0, 1'b0);
        add_cmd(pfps_pkg::MODE_READ, 127, 0, 1'b0);
        // zero scroll, one-row scroll, near-full scroll
        add_cmd(pfps_pkg::MODE_SCROLL, 0, 0, 1'b0);
        add_cmd(pfps_pkg::MODE_READ, 0, 0, 1'b0);
        add_cmd(pfps_pkg::MODE_SCROLL, 1, 0, 1'b0);
        add_cmd(pfps_pkg::MODE_READ, 896, 0, 1'b0);
        add_cmd(pfps_pkg::MODE_SCROLL, 62, 0, 1'b0);
        add_cmd(pfps_pkg::MODE_READ, 0, 0, 1'b0);
        // scroll of a full screen or more clears
        add_cmd(pfps_pkg::MODE_DRAW, 9, 40, 1'b1);
        add_cmd(pfps_pkg::MODE_SCROLL, 64, 0, 1'b0);
        add_cmd(pfps_pkg::MODE_DRAW, 9, 40, 1'b1);
        add_cmd(pfps_pkg::MODE_SCROLL, 255, 0, 1'b0);
        add_cmd(pfps_pkg::MODE_CLEAR, 0, 0, 1'b0);

        // random mix, drawing dense in the first columns so reads see data
        for (int n = 0; n < RAND_CMDS; n++) begin
            r = $urandom_range(99);
            if (r < 50) begin
                r = $urandom_range(99);
                x = (r < 70) ? $urandom_range(15)
                  : (r < 90) ? $urandom_range(127) : $urandom_range(255);
                y = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(63);
                add_cmd(pfps_pkg::MODE_DRAW, x, y, $urandom_range(3) != 0);
            end else if (r < 85) begin
                if ($urandom_range(9) < 7)
                    add_cmd(pfps_pkg::MODE_READ,
                            $urandom_range(7) * FB_W + $urandom_range(15), 0, 1'b0);
                else
                    add_cmd(pfps_pkg::MODE_READ, $urandom_range(1023), 0, 1'b0);
            end else if (r < 96) begin
                r = $urandom_range(99);
                x = (r < 10) ? 0
                  : (r < 70) ? $urandom_range(12, 1)
                  : (r < 85) ? $urandom_range(63, 13) : $urandom_range(255, 64);
                add_cmd(pfps_pkg::MODE_SCROLL, x, 0, 1'b0);
            end else begin
                add_cmd(pfps_pkg::MODE_CLEAR, 0, 0, 1'b0);
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all commands accepted, then all results in, then a short drain
        while (pending_cmds.size() > 0 || start) @(posedge i_clk);
        while (due_bytes.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
src/pfps_pkg.sv
src/pfps_ram.sv
src/page_framebuffer_pixel_scroll.sv
tb/tb_page_framebuffer_pixel_scroll.sv
